// ----- rtl/pec_pkg.sv -----
// ---------------------------------------------------------------------------
// pec_pkg
// Types, constants and helpers shared by the pointer-to-expression blocks.
// ---------------------------------------------------------------------------
`default_nettype none
package pec_pkg;

   localparam int HEIGHT_W   = 15;
   localparam int DELAY_W    = 16;
   localparam int POS_W      = 16;
   localparam int ELAPSED_W  = 10;
   localparam int CC_W       = 7;
   localparam int NUM_W      = 22;   // holds 127 * 32767
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CC_W-1:0] CC_MAX = 7'd127;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_DELAY   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_MODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MOD_ENABLE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_ENABLE    = 3'd4;

   // curve codes
   localparam logic [1:0] CURVE_LINEAR = 2'd0;
   localparam logic [1:0] CURVE_SQUARE = 2'd1;
   localparam logic [1:0] CURVE_ROOT   = 2'd2;

   typedef struct packed {
      logic signed [POS_W-1:0] x_position;
      logic signed [POS_W-1:0] y_position;
      logic [ELAPSED_W-1:0]    elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [CC_W-1:0] note_velocity;
      logic            direction_changed;
      logic [CC_W-1:0] controller_value;
      logic            modulation_send;
      logic            expression_send;
   } rsp_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] screen_height;
      logic [DELAY_W-1:0]  decay_delay_ms;
      logic [1:0]          curve_mode;
      logic                modulation_enable;
      logic                expression_enable;
   } cfg_type;

   // queue entry: the sample plus the velocity numerator 127*(h - clamp(y))
   typedef struct packed {
      logic signed [POS_W-1:0] x_position;
      logic signed [POS_W-1:0] y_position;
      logic [ELAPSED_W-1:0]    elapsed_ms;
      logic [NUM_W-1:0]        numerator;
   } work_type;

   typedef struct packed {
      logic                start;
      logic                sqrt_mode;
      logic [NUM_W-1:0]    num;
      logic [HEIGHT_W-1:0] den;
   } arith_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_VEL,
      ST_SHAPE,
      ST_OUT
   } back_state_type;

   // a height of zero acts as one
   function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] h);
      return (h == '0) ? HEIGHT_W'(1) : h;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/pointer_to_expression_controller_core.sv -----
// ---------------------------------------------------------------------------
// pointer_to_expression_controller_core
// Turns pointer samples into note velocity and a curved or decaying
// controller value with per-output send flags.
// ---------------------------------------------------------------------------
// A sample that is skipped (same position, no decay pending) leaves the
// execution stage and produces no result. A processed sample goes through
// the velocity divide with a linear or square curve, a decay step or a held
// value, and through a square-root step as well when the square-root
// curve is applied; both steps run in the shared iterative divide/root
// unit, which resolves one result bit per cycle and is used once or twice per
// sample. A two-entry queue lets new samples be taken while one is executing,
// and the result register lets execution go on while a result waits to be
// transferred. Configuration writes take effect at once and belong in idle
// periods.
// ---------------------------------------------------------------------------
`default_nettype none
module pointer_to_expression_controller_core #(
   parameter int DECAY_SPAN_MS = 200
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire pec_pkg::req_type                   req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output pec_pkg::rsp_type                        rsp_payload,
   input  wire logic                               csr_wr_en,
   input  wire logic [pec_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pec_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   pec_pkg::cfg_type  cfg_ff, cfg_in;
   pec_pkg::work_type q_data, q_head;
   logic              q_push, q_full, q_pop, q_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pec_pkg::CSR_SCREEN_HEIGHT: begin
               cfg_in.screen_height = csr_wdata[pec_pkg::HEIGHT_W-1:0];
            end
            pec_pkg::CSR_DECAY_DELAY: begin
               cfg_in.decay_delay_ms = csr_wdata[pec_pkg::DELAY_W-1:0];
            end
            pec_pkg::CSR_CURVE_MODE: begin
               cfg_in.curve_mode = csr_wdata[1:0];
            end
            pec_pkg::CSR_MOD_ENABLE: begin
               cfg_in.modulation_enable = csr_wdata[0];
            end
            pec_pkg::CSR_EXP_ENABLE: begin
               cfg_in.expression_enable = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_height     <= pec_pkg::HEIGHT_W'(1080);
         cfg_ff.decay_delay_ms    <= pec_pkg::DELAY_W'(100);
         cfg_ff.curve_mode        <= pec_pkg::CURVE_LINEAR;
         cfg_ff.modulation_enable <= 1'b1;
         cfg_ff.expression_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pec_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .screen_height (cfg_ff.screen_height),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_data)
   );

   pec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   pec_back #(
      .DECAY_SPAN_MS (DECAY_SPAN_MS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- rtl/pec_front.sv -----
// ---------------------------------------------------------------------------
// pec_front
// Accepts samples, clamps y and forms the velocity numerator for the queue.
// ---------------------------------------------------------------------------
`default_nettype none
module pec_front (
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire pec_pkg::req_type                 req_payload,
   input  wire logic [pec_pkg::HEIGHT_W-1:0]     screen_height,
   input  wire logic                             q_full,
   output logic                                  q_push,
   output pec_pkg::work_type                     q_data
);

   logic [pec_pkg::HEIGHT_W-1:0] h_eff;
   logic [pec_pkg::HEIGHT_W-1:0] y_clamped;
   logic [pec_pkg::HEIGHT_W-1:0] span;

   assign h_eff = pec_pkg::eff_height(screen_height);

   always_comb begin
      if (req_payload.y_position[pec_pkg::POS_W-1]) begin
         y_clamped = '0;
      end else if ({1'b0, req_payload.y_position[pec_pkg::POS_W-2:0]} >
                   {1'b0, h_eff}) begin
         y_clamped = h_eff;
      end else begin
         y_clamped = req_payload.y_position[pec_pkg::HEIGHT_W-1:0];
      end
   end

   assign span = h_eff - y_clamped;

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   always_comb begin
      q_data.x_position = req_payload.x_position;
      q_data.y_position = req_payload.y_position;
      q_data.elapsed_ms = req_payload.elapsed_ms;
      // 127 * span as (span << 7) - span
      q_data.numerator  = pec_pkg::NUM_W'({span, 7'b0}) - pec_pkg::NUM_W'(span);
   end

endmodule
`default_nettype wire

// ----- rtl/pec_queue.sv -----
// ---------------------------------------------------------------------------
// pec_queue
// Short FIFO between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none
module pec_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire pec_pkg::work_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   valid,
   output pec_pkg::work_type      head
);

   localparam int DEPTH = pec_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pec_pkg::work_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/pec_arith.sv -----
// ---------------------------------------------------------------------------
// pec_arith
// Shared iterative unit: 7-bit quotient divide or 7-bit integer square root,
// one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module pec_arith (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pec_pkg::arith_cmd_type        cmd,
   output logic                               done,
   output logic [pec_pkg::CC_W-1:0]           result
);

   localparam int BIT_W = $clog2(pec_pkg::CC_W);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [BIT_W-1:0]                bit_ff, bit_in;
   logic                            sqrt_ff, sqrt_in;
   logic [pec_pkg::NUM_W-1:0]       rem_ff, rem_in;
   logic [pec_pkg::HEIGHT_W-1:0]    den_ff, den_in;
   logic [pec_pkg::CC_W-1:0]        res_ff, res_in;

   logic [pec_pkg::CC_W-1:0]        bit_mask;
   logic [pec_pkg::CC_W-1:0]        cand;
   logic [2*pec_pkg::CC_W-1:0]      cand_sq;
   logic [pec_pkg::NUM_W-1:0]       den_shift;

   assign bit_mask  = pec_pkg::CC_W'(1) << bit_ff;
   assign cand      = res_ff | bit_mask;
   assign cand_sq   = (2*pec_pkg::CC_W)'(cand) * (2*pec_pkg::CC_W)'(cand);
   assign den_shift = pec_pkg::NUM_W'(den_ff) << bit_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      sqrt_in = sqrt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      res_in  = res_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         bit_in  = BIT_W'(pec_pkg::CC_W - 1);
         sqrt_in = cmd.sqrt_mode;
         rem_in  = cmd.num;
         den_in  = cmd.den;
         res_in  = '0;
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            if (pec_pkg::NUM_W'(cand_sq) <= rem_ff) begin
               res_in = cand;
            end
         end else if (rem_ff >= den_shift) begin
            rem_in = rem_ff - den_shift;
            res_in = res_ff | bit_mask;
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - BIT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff  <= bit_in;
      sqrt_ff <= sqrt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

// ----- rtl/pec_back.sv -----
// ---------------------------------------------------------------------------
// pec_back
// Executes queued samples: skip test, direction, velocity, curve or decay,
// send flags, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
module pec_back #(
   parameter int DECAY_SPAN_MS = 200
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pec_pkg::cfg_type  cfg,
   input  wire logic              q_valid,
   input  wire pec_pkg::work_type q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pec_pkg::rsp_type       rsp_payload
);

   localparam int SPAN_W = $clog2(DECAY_SPAN_MS + 1);
   localparam int PROD_W = pec_pkg::CC_W + SPAN_W;
   localparam logic [SPAN_W-1:0] SPAN = SPAN_W'(DECAY_SPAN_MS);
   localparam int POS_W  = pec_pkg::POS_W;
   localparam int CC_W   = pec_pkg::CC_W;
   localparam int DLY_W  = pec_pkg::DELAY_W;

   // reciprocal of the decay span, exact for every level times remaining span
   localparam longint DECAY_TOP = longint'(pec_pkg::CC_MAX) * longint'(DECAY_SPAN_MS) *
                                  longint'(DECAY_SPAN_MS);
   localparam int     RECIP_K   = $clog2(DECAY_TOP + 1);
   localparam longint RECIP_M   = ((longint'(1) << RECIP_K) + longint'(DECAY_SPAN_MS) - 1) /
                                  longint'(DECAY_SPAN_MS);
   localparam int     RECIP_W   = $clog2(RECIP_M + 1);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_M);

   pec_pkg::back_state_type state_ff, state_in;
   pec_pkg::work_type       item_ff, item_in;
   logic signed [POS_W-1:0] prev_x_ff, prev_x_in;
   logic signed [POS_W-1:0] prev_y_ff, prev_y_in;
   logic                    heading_ff, heading_in;
   logic                    moved_ff, moved_in;
   logic [DLY_W-1:0]        idle_ff, idle_in;
   logic [CC_W-1:0]         sent_mod_ff, sent_mod_in;
   logic [CC_W-1:0]         sent_exp_ff, sent_exp_in;
   logic                    moving_ff, moving_in;
   logic                    dc_ff, dc_in;
   logic [CC_W-1:0]         vel_ff, vel_in;
   logic [CC_W-1:0]         cc_ff, cc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   pec_pkg::rsp_type        rsp_ff, rsp_in;
   logic [PROD_W-1:0]       decay_prod_ff, decay_prod_in;

   pec_pkg::arith_cmd_type  arith_cmd;
   logic                    arith_done;
   logic [CC_W-1:0]         arith_res;

   logic [DLY_W:0]          idle_sum;
   logic [DLY_W-1:0]        idle_sat;
   logic                    same_pos, pending, skip;
   logic                    moving_now, heading_now;
   logic                    overdue, needs_shape;
   logic [DLY_W-1:0]        past;
   logic [SPAN_W-1:0]       past_c, span_left;
   logic [PROD_W+RECIP_W-1:0] decay_scaled;
   logic [CC_W-1:0]         decay_cc;
   logic [2*CC_W-1:0]       vel_sq, vel_127;
   logic [2*CC_W-1:0]       sq_sum;
   logic [CC_W-1:0]         sq_curve;
   logic                    out_load;
   logic                    mod_send, exp_send;

   pec_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (arith_cmd),
      .done   (arith_done),
      .result (arith_res)
   );

   // classification of the queue head against current state
   assign idle_sum    = {1'b0, idle_ff} + (DLY_W+1)'(q_head.elapsed_ms);
   assign idle_sat    = idle_sum[DLY_W] ? '1 : idle_sum[DLY_W-1:0];
   assign same_pos    = (q_head.x_position == prev_x_ff) &&
                        (q_head.y_position == prev_y_ff);
   assign pending     = (idle_sat > cfg.decay_delay_ms) &&
                        ((sent_mod_ff != '0) || (sent_exp_ff != '0));
   assign skip        = same_pos & ~pending;
   assign moving_now  = (q_head.x_position != prev_x_ff);
   assign heading_now = (q_head.x_position > prev_x_ff);

   // decay and curve operands for the item in flight
   assign overdue     = ~moving_ff && (idle_ff > cfg.decay_delay_ms);
   assign needs_shape = moving_ff && (cfg.curve_mode == pec_pkg::CURVE_ROOT);
   assign past        = idle_ff - cfg.decay_delay_ms;
   assign past_c      = ({1'b0, past} > (DLY_W+1)'(DECAY_SPAN_MS)) ? SPAN
                                                                   : SPAN_W'(past);
   assign span_left   = SPAN - past_c;
   assign decay_prod_in = PROD_W'(sent_mod_ff) * PROD_W'(span_left);
   // operands hold still while the velocity divide runs
   assign decay_scaled  = (PROD_W+RECIP_W)'(decay_prod_ff) * (PROD_W+RECIP_W)'(RECIP);
   assign decay_cc      = decay_scaled[RECIP_K +: CC_W];
   assign vel_sq      = (2*CC_W)'(arith_res) * (2*CC_W)'(arith_res);
   assign vel_127     = (2*CC_W)'(arith_res) * (2*CC_W)'(pec_pkg::CC_MAX);
   // divide by 127 = 2^7 - 1 with a shift and add
   assign sq_sum      = vel_sq + (vel_sq >> CC_W) + (2*CC_W)'(1);
   assign sq_curve    = sq_sum[2*CC_W-1:CC_W];

   assign out_load    = (state_ff == pec_pkg::ST_OUT) && (~rsp_valid_ff || ~rsp_stall);
   assign mod_send    = cfg.modulation_enable && (cc_ff != sent_mod_ff);
   assign exp_send    = cfg.expression_enable && (cc_ff != sent_exp_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pec_pkg::ST_IDLE: begin
            if (q_valid && !skip) begin
               state_in = pec_pkg::ST_VEL;
            end
         end
         pec_pkg::ST_VEL: begin
            if (arith_done) begin
               state_in = needs_shape ? pec_pkg::ST_SHAPE : pec_pkg::ST_OUT;
            end
         end
         pec_pkg::ST_SHAPE: begin
            if (arith_done) begin
               state_in = pec_pkg::ST_OUT;
            end
         end
         pec_pkg::ST_OUT: begin
            if (out_load) begin
               state_in = pec_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pec_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop        = 1'b0;
      arith_cmd    = '0;
      item_in      = item_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      heading_in   = heading_ff;
      moved_in     = moved_ff;
      idle_in      = idle_ff;
      sent_mod_in  = sent_mod_ff;
      sent_exp_in  = sent_exp_ff;
      moving_in    = moving_ff;
      dc_in        = dc_ff;
      vel_in       = vel_ff;
      cc_in        = cc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         pec_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               idle_in = (moving_now && !skip) ? '0 : idle_sat;
               if (!skip) begin
                  item_in    = q_head;
                  moving_in  = moving_now;
                  dc_in      = moving_now & moved_ff & (heading_now != heading_ff);
                  if (moving_now) begin
                     heading_in = heading_now;
                     moved_in   = 1'b1;
                  end
                  arith_cmd.start = 1'b1;
                  arith_cmd.num   = q_head.numerator;
                  arith_cmd.den   = pec_pkg::eff_height(cfg.screen_height);
               end
            end
         end
         pec_pkg::ST_VEL: begin
            if (arith_done) begin
               vel_in = arith_res;
               if (moving_ff) begin
                  cc_in = (cfg.curve_mode == pec_pkg::CURVE_SQUARE) ? sq_curve : arith_res;
                  if (cfg.curve_mode == pec_pkg::CURVE_ROOT) begin
                     arith_cmd.start     = 1'b1;
                     arith_cmd.sqrt_mode = 1'b1;
                     arith_cmd.num       = pec_pkg::NUM_W'(vel_127);
                  end
               end else if (overdue) begin
                  cc_in = decay_cc;
               end else begin
                  cc_in = sent_mod_ff;
               end
            end
         end
         pec_pkg::ST_SHAPE: begin
            if (arith_done) begin
               cc_in = arith_res;
            end
         end
         pec_pkg::ST_OUT: begin
            if (out_load) begin
               rsp_valid_in                = 1'b1;
               rsp_in.note_velocity        = vel_ff;
               rsp_in.direction_changed    = dc_ff;
               rsp_in.controller_value     = cc_ff;
               rsp_in.modulation_send      = mod_send;
               rsp_in.expression_send      = exp_send;
               if (mod_send) begin
                  sent_mod_in = cc_ff;
               end
               if (exp_send) begin
                  sent_exp_in = cc_ff;
               end
               prev_x_in = item_ff.x_position;
               prev_y_in = item_ff.y_position;
               if (overdue) begin
                  moved_in = 1'b0;
               end
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pec_pkg::ST_IDLE;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         heading_ff   <= 1'b0;
         moved_ff     <= 1'b0;
         idle_ff      <= '0;
         sent_mod_ff  <= '0;
         sent_exp_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         heading_ff   <= heading_in;
         moved_ff     <= moved_in;
         idle_ff      <= idle_in;
         sent_mod_ff  <= sent_mod_in;
         sent_exp_ff  <= sent_exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      moving_ff     <= moving_in;
      dc_ff         <= dc_in;
      vel_ff        <= vel_in;
      cc_ff         <= cc_in;
      rsp_ff        <= rsp_in;
      decay_prod_ff <= decay_prod_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
